@@ design/wsd_pkg.sv @@
package wsd_pkg;

  // kept length bits of the extended payload length
  localparam int LENGTH_BITS = 63;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_PONG    = 2'd2;
  localparam logic [1:0] KIND_CLOSE   = 2'd3;

  // frame opcodes with special handling
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  // 7-bit length codes announcing an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // ping opcode byte xor this gives pong
  localparam logic [7:0] PONG_FLIP = 8'h03;

  // queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified result waiting for the output stage
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       last;
  } wsd_entry_t;

endpackage

@@ design/wsd_front.sv @@
module wsd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                in_ready,
  input  logic                queue_full,
  output logic                push,
  output wsd_pkg::wsd_entry_t push_entry
);

  typedef enum logic [2:0] {
    PH_OPCODE = 3'd0,
    PH_LEN    = 3'd1,
    PH_EXT    = 3'd2,
    PH_KEY    = 3'd3,
    PH_PAY    = 3'd4,
    PH_CLOSED = 3'd5
  } phase_t;

  phase_t                          phase, phase_next;
  logic [3:0]                      opcode, opcode_next;
  logic [3:0]                      ext_left, ext_left_next;
  logic [wsd_pkg::LENGTH_BITS-1:0] pay_left, pay_left_next;
  logic [31:0]                     mask_key, mask_key_next;
  logic [1:0]                      mask_pos, mask_pos_next;
  logic                            accept;
  logic                            is_ping;
  logic                            final_byte;
  logic [7:0]                      key_byte;

  // take a byte whenever the queue has room
  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign is_ping  = (opcode == wsd_pkg::OP_PING);

  // last payload byte when at most one byte remains
  assign final_byte = (pay_left[wsd_pkg::LENGTH_BITS-1:1] == '0);

  // key byte for the current payload position, first key byte first
  always_comb begin
    unique case (mask_pos)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      2'd3: key_byte = mask_key[7:0];
    endcase
  end

  // header and payload parsing, one result at most per byte
  always_comb begin
    phase_next        = phase;
    opcode_next       = opcode;
    ext_left_next     = ext_left;
    pay_left_next     = pay_left;
    mask_key_next     = mask_key;
    mask_pos_next     = mask_pos;
    push              = 1'b0;
    push_entry.kind   = wsd_pkg::KIND_PONG;
    push_entry.data   = in_byte;
    push_entry.key    = 8'd0;
    push_entry.opcode = opcode;
    push_entry.last   = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_OPCODE: begin
          opcode_next       = in_byte[3:0];
          pay_left_next     = '0;
          ext_left_next     = 4'd0;
          mask_pos_next     = 2'd0;
          phase_next        = PH_LEN;
          push_entry.opcode = in_byte[3:0];
          push_entry.data   = in_byte ^ wsd_pkg::PONG_FLIP;
          push              = (in_byte[3:0] == wsd_pkg::OP_PING);
        end
        PH_LEN: begin
          push = is_ping;
          if (in_byte[6:0] == wsd_pkg::LEN_EXT16) begin
            ext_left_next = wsd_pkg::EXT16_BYTES;
            phase_next    = PH_EXT;
          end else if (in_byte[6:0] == wsd_pkg::LEN_EXT64) begin
            ext_left_next = wsd_pkg::EXT64_BYTES;
            phase_next    = PH_EXT;
          end else begin
            pay_left_next = {{(wsd_pkg::LENGTH_BITS-7){1'b0}}, in_byte[6:0]};
            phase_next    = PH_KEY;
          end
        end
        PH_EXT: begin
          push          = is_ping;
          pay_left_next = {pay_left[wsd_pkg::LENGTH_BITS-9:0], in_byte};
          ext_left_next = ext_left - 4'd1;
          if (ext_left == 4'd1 || ext_left == 4'd0) begin
            ext_left_next = 4'd0;
            phase_next    = PH_KEY;
          end
        end
        PH_KEY: begin
          mask_key_next = {mask_key[23:0], in_byte};
          mask_pos_next = mask_pos + 2'd1;
          push          = is_ping;
          if (mask_pos == 2'd3) begin
            if (pay_left == '0) begin
              // header-only frame ends on the last key byte
              phase_next      = PH_OPCODE;
              push_entry.last = 1'b1;
              if (is_ping) begin
                push = 1'b1;
              end else if (opcode == wsd_pkg::OP_PONG) begin
                push = 1'b0;
              end else if (opcode == wsd_pkg::OP_CLOSE) begin
                phase_next      = PH_CLOSED;
                push            = 1'b1;
                push_entry.kind = wsd_pkg::KIND_CLOSE;
                push_entry.data = 8'd0;
              end else begin
                push            = 1'b1;
                push_entry.kind = wsd_pkg::KIND_EMPTY;
                push_entry.data = 8'd0;
              end
            end else begin
              phase_next = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          pay_left_next   = final_byte ? '0 : pay_left - 1'b1;
          mask_pos_next   = mask_pos + 2'd1;
          push_entry.last = final_byte;
          if (final_byte) begin
            phase_next = PH_OPCODE;
          end
          if (is_ping) begin
            push = 1'b1;
          end else if (opcode == wsd_pkg::OP_PONG) begin
            push = 1'b0;
          end else if (opcode == wsd_pkg::OP_CLOSE) begin
            // close payload is swallowed, result on its final byte
            push            = final_byte;
            push_entry.kind = wsd_pkg::KIND_CLOSE;
            push_entry.data = 8'd0;
            if (final_byte) begin
              phase_next = PH_CLOSED;
            end
          end else begin
            push            = 1'b1;
            push_entry.kind = wsd_pkg::KIND_PAYLOAD;
            push_entry.key  = key_byte;
          end
        end
        PH_CLOSED: begin
          push = 1'b0;
        end
        default: begin
          phase_next = PH_CLOSED;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_OPCODE;
      opcode   <= 4'd0;
      ext_left <= 4'd0;
      pay_left <= '0;
      mask_key <= 32'd0;
      mask_pos <= 2'd0;
    end else begin
      phase    <= phase_next;
      opcode   <= opcode_next;
      ext_left <= ext_left_next;
      pay_left <= pay_left_next;
      mask_key <= mask_key_next;
      mask_pos <= mask_pos_next;
    end
  end

endmodule

@@ design/wsd_queue.sv @@
module wsd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wsd_pkg::wsd_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output wsd_pkg::wsd_entry_t head
);

  wsd_pkg::wsd_entry_t         slots [wsd_pkg::QUEUE_DEPTH];
  logic [wsd_pkg::QPTR_W-1:0]  wr_ptr;
  logic [wsd_pkg::QPTR_W-1:0]  rd_ptr;
  logic [wsd_pkg::QCNT_W-1:0]  count;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count == wsd_pkg::QCNT_W'(wsd_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/wsd_back.sv @@
module wsd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                queue_empty,
  input  wsd_pkg::wsd_entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_data,
  output logic [3:0]          out_opcode,
  output logic                out_last
);

  // load the output register when it is free or being drained
  assign pop = !queue_empty && (!out_valid || out_ready);

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register, unmasking applied on the way in
  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind   <= head.kind;
      out_data   <= head.data ^ head.key;
      out_opcode <= head.opcode;
      out_last   <= head.last;
    end
  end

endmodule

@@ design/websocket_frame_deframer.sv @@
// Client frame deframer: takes a byte stream of masked client frames and
// gives one result per data payload byte, empty message, pong echo byte or close.
// Input: s_tvalid/s_tready/s_tdata, one raw stream byte per transfer.
// Output: m_tvalid/m_tready/m_tdata/m_tuser/m_tlast, m_tuser carries the
// result kind, m_tlast marks the final result of a frame.
// Throughput: one input byte per cycle while the queue has room; the parser
// decides each byte in the cycle it is accepted and writes at most one
// result into a 4-entry queue. The queue is written at the accepting edge;
// the output register loads the result once it is free or being drained.
// Stall: when the receiver holds m_tready low the output register holds, the
// queue fills and s_tready drops once all four entries are taken.
// Reset: synchronous, active high; the parser waits for a frame's opcode
// byte, the queue and output register are emptied. After a close frame all
// bytes are accepted and dropped until the next reset.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] data, [11:8] frame_opcode, [15:12] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  wsd_pkg::wsd_entry_t push_entry;
  wsd_pkg::wsd_entry_t head;
  logic                push;
  logic                pop;
  logic                queue_full;
  logic                queue_empty;
  logic [7:0]          out_data;
  logic [3:0]          out_opcode;

  // header parser and classifier
  wsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .in_ready   (s_tready),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // result queue
  wsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .empty      (queue_empty),
    .head       (head)
  );

  // unmasking and output register
  wsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (m_tuser),
    .out_data    (out_data),
    .out_opcode  (out_opcode),
    .out_last    (m_tlast)
  );

  assign m_tdata = {4'd0, out_opcode, out_data};

endmodule

@@ tb/tb_websocket_frame_deframer.sv @@
`timescale 1ns / 100ps

module tb_websocket_frame_deframer;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 60;
  localparam int RANDOM_BYTES = 140;
  localparam int STEADY_BYTES = 60;

  // parser position, mirrors the block's frame walk
  typedef enum logic [2:0] {
    P_OPCODE, P_LEN, P_EXT, P_KEY, P_PAY, P_CLOSED
  } parse_phase_t;

  // how the payload length is carried in the header
  typedef enum logic [1:0] {LF_SHORT, LF_EXT16, LF_EXT64} len_form_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
  } deframe_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  // deframer state as predicted
  parse_phase_t                    ph       = P_OPCODE;
  logic [3:0]                      cur_op   = '0;
  logic [3:0]                      ext_left = '0;
  logic [wsd_pkg::LENGTH_BITS-1:0] pay_left = '0;
  logic [31:0]                     key_reg  = '0;
  logic [1:0]                      kpos     = '0;

  deframe_result_t pending_results[$];
  int  errors      = 0;
  int  bytes_sent  = 0;
  int  cycle_count = 0;
  bit  calm        = 1'b0;
  int  hold_serial = 0;
  int  hold_served = 0;
  int  hold_left   = 0;

  websocket_frame_deframer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void queue_result(input logic [1:0] kind, input logic [7:0] data,
                                       input logic last);
    pending_results.push_back('{kind: kind, data: data, opcode: cur_op, last: last});
  endfunction

  // frame over with no payload byte left
  function automatic void finish_empty_frame(input logic [7:0] b);
    ph = P_OPCODE;
    if (cur_op == wsd_pkg::OP_PING) begin
      queue_result(wsd_pkg::KIND_PONG, b, 1'b1);
    end else if (cur_op == wsd_pkg::OP_CLOSE) begin
      ph = P_CLOSED;
      queue_result(wsd_pkg::KIND_CLOSE, 8'h00, 1'b1);
    end else if (cur_op != wsd_pkg::OP_PONG) begin
      queue_result(wsd_pkg::KIND_EMPTY, 8'h00, 1'b1);
    end
  endfunction

  // advance the predicted parser by one accepted stream byte
  function automatic void deframe_byte(input logic [7:0] b);
    logic       ping;
    logic       at_end;
    logic [7:0] kb;
    ping = (cur_op == wsd_pkg::OP_PING);
    case (ph)
      P_OPCODE: begin
        cur_op   = b[3:0];
        pay_left = '0;
        ext_left = '0;
        kpos     = '0;
        ph       = P_LEN;
        if (cur_op == wsd_pkg::OP_PING)
          queue_result(wsd_pkg::KIND_PONG, b ^ wsd_pkg::PONG_FLIP, 1'b0);
      end
      P_LEN: begin
        if (b[6:0] == wsd_pkg::LEN_EXT16) begin
          ext_left = wsd_pkg::EXT16_BYTES;
          ph       = P_EXT;
        end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
          ext_left = wsd_pkg::EXT64_BYTES;
          ph       = P_EXT;
        end else begin
          pay_left = {{(wsd_pkg::LENGTH_BITS-7){1'b0}}, b[6:0]};
          ph       = P_KEY;
        end
        if (ping) queue_result(wsd_pkg::KIND_PONG, b, 1'b0);
      end
      P_EXT: begin
        // big-endian, bits above the kept width fall off the top
        pay_left = {pay_left[wsd_pkg::LENGTH_BITS-9:0], b};
        if (ext_left != 0) ext_left = ext_left - 1'b1;
        if (ext_left == 0) ph = P_KEY;
        if (ping) queue_result(wsd_pkg::KIND_PONG, b, 1'b0);
      end
      P_KEY: begin
        key_reg = {key_reg[23:0], b};
        kpos    = kpos + 1'b1;
        if (kpos == 0 && pay_left == 0) begin
          finish_empty_frame(b);
        end else begin
          if (kpos == 0) ph = P_PAY;
          if (ping) queue_result(wsd_pkg::KIND_PONG, b, 1'b0);
        end
      end
      P_PAY: begin
        if (pay_left != 0) pay_left = pay_left - 1'b1;
        at_end = (pay_left == 0);
        kb     = 8'(key_reg >> (8 * (3 - kpos)));
        kpos   = kpos + 1'b1;
        if (at_end) ph = P_OPCODE;
        if (cur_op == wsd_pkg::OP_PING) begin
          queue_result(wsd_pkg::KIND_PONG, b, at_end);
        end else if (cur_op == wsd_pkg::OP_CLOSE) begin
          if (at_end) begin
            ph = P_CLOSED;
            queue_result(wsd_pkg::KIND_CLOSE, 8'h00, 1'b1);
          end
        end else if (cur_op != wsd_pkg::OP_PONG) begin
          queue_result(wsd_pkg::KIND_PAYLOAD, b ^ kb, at_end);
        end
      end
      default: ;
    endcase
  endfunction

  // one byte transfer on the input side, with random gaps before it
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] head, input len_form_t form,
                            input logic [63:0] len_field, input logic mask_bit,
                            input logic [31:0] key);
    longint unsigned pay_n;
    case (form)
      LF_SHORT: pay_n = 64'(len_field[6:0]);
      LF_EXT16: pay_n = 64'(len_field[15:0]);
      default:  pay_n = 64'(len_field[wsd_pkg::LENGTH_BITS-1:0]);
    endcase
    send_byte(head);
    case (form)
      LF_SHORT: send_byte({mask_bit, len_field[6:0]});
      LF_EXT16: begin
        send_byte({mask_bit, wsd_pkg::LEN_EXT16});
        send_byte(len_field[15:8]);
        send_byte(len_field[7:0]);
      end
      default: begin
        send_byte({mask_bit, wsd_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len_field[8*i +: 8]);
      end
    endcase
    for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    repeat (pay_n) send_byte(8'($urandom));
  endtask

  // well-formed frame, any opcode but close, mostly short
  task automatic send_random_frame();
    logic [7:0] head;
    int         r;
    head = 8'($urandom);
    r    = $urandom_range(99);
    if (r < 15) head[3:0] = wsd_pkg::OP_PING;
    else if (r < 25) head[3:0] = wsd_pkg::OP_PONG;
    else if (head[3:0] == wsd_pkg::OP_CLOSE) head[1] = 1'b1;
    r = $urandom_range(99);
    if (r < 2)
      send_frame(head, LF_SHORT, 64'($urandom_range(100, 125)), 1'($urandom), $urandom);
    else if (r < 70)
      send_frame(head, LF_SHORT, 64'($urandom_range(0, 12)), 1'($urandom), $urandom);
    else if (r < 88)
      send_frame(head, LF_EXT16, 64'($urandom_range(0, 20)), 1'($urandom), $urandom);
    else if (r < 99)
      send_frame(head, LF_EXT64, 64'($urandom_range(0, 8)), 1'($urandom), $urandom);
    else
      send_frame(head, LF_EXT16, 64'($urandom_range(256, 270)), 1'($urandom), $urandom);
  endtask

  // raw byte that neither closes the stream nor opens a long frame
  function automatic logic [7:0] tame_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (ph == P_OPCODE && b[3:0] == wsd_pkg::OP_CLOSE) b[0] = 1'b1;
    if (ph == P_LEN) b[6:4] = 3'b000;
    return b;
  endfunction

  // loose bytes, then filler until the parser is back at a frame start
  task automatic send_noise();
    repeat ($urandom_range(2, 10)) send_byte(tame_byte());
    while (ph != P_OPCODE) send_byte(tame_byte());
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_header_extremes();
    send_frame(8'h81, LF_SHORT, 64'd5, 1'b1, 32'hFFFF_FFFF);
    send_frame(8'h82, LF_SHORT, 64'd0, 1'b1, $urandom);
    send_frame(8'h00, LF_SHORT, 64'd0, 1'b0, 32'h0000_0000);
    send_frame(8'h01, LF_SHORT, 64'd3, 1'b0, $urandom);
    send_frame(8'hF2, LF_EXT16, 64'd4, 1'b1, $urandom);
    send_frame(8'h82, LF_EXT16, 64'd0, 1'b1, $urandom);
    send_frame(8'hFF, LF_EXT64, 64'h8000_0000_0000_0001, 1'b1, $urandom);
    send_frame(8'h82, LF_EXT64, 64'h8000_0000_0000_0000, 1'b1, $urandom);
    send_frame(8'h02, LF_EXT64, 64'd6, 1'b0, $urandom);
  endtask

  task automatic test_ping_pong();
    send_frame(8'h89, LF_SHORT, 64'd3, 1'b1, $urandom);
    send_frame(8'h89, LF_SHORT, 64'd0, 1'b1, $urandom);
    send_frame(8'h19, LF_EXT16, 64'd2, 1'b0, $urandom);
    send_frame(8'h8A, LF_SHORT, 64'd4, 1'b1, $urandom);
    send_frame(8'h8A, LF_SHORT, 64'd0, 1'b1, $urandom);
    send_frame(8'h0A, LF_EXT64, 64'd1, 1'b1, $urandom);
  endtask

  // receiver stalls long while the sender keeps offering bytes
  task automatic test_backpressure();
    hold_serial <= hold_serial + 1;
    calm = 1'b1;
    send_frame(8'h82, LF_SHORT, 64'd40, 1'b1, $urandom);
    calm = 1'b0;
    s_tvalid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_steady_stream();
    int stop_at;
    stop_at = bytes_sent + STEADY_BYTES;
    calm = 1'b1;
    while (bytes_sent < stop_at) send_random_frame();
    calm = 1'b0;
  endtask

  task automatic test_random_stream();
    int stop_at;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 15) send_noise();
      else send_random_frame();
    end
  endtask

  // close with payload, then bytes that must be swallowed
  task automatic test_close_frame();
    send_frame(8'h88, LF_SHORT, 64'd2, 1'b1, $urandom);
    send_byte(8'h81);
    send_byte(8'h85);
    repeat (18) send_byte(8'($urandom));
  endtask

  // receiver ready, random or held off on request
  always @(posedge clk) begin
    if (hold_serial != hold_served) begin
      hold_served <= hold_serial;
      hold_left   <= HOLD_CYCLES;
      m_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 34);
    end
  end

  // compare each output transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    deframe_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d tdata=%h last=%b",
                                  m_tuser, m_tdata, m_tlast));
      end else begin
        e = pending_results.pop_front();
        if (m_tuser !== e.kind || m_tdata !== {4'h0, e.opcode, e.data} ||
            m_tlast !== e.last)
          report_mismatch($sformatf(
            "kind %0d/%0d data %h/%h opcode %h/%h pad %h last %b/%b (got/exp)",
            m_tuser, e.kind, m_tdata[7:0], e.data, m_tdata[11:8], e.opcode,
            m_tdata[15:12], m_tlast, e.last));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_extremes();
    test_ping_pong();
    test_backpressure();
    test_steady_stream();
    test_random_stream();
    test_close_frame();
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
